/* src/trapped_water_volume_unit_macros.svh */
// Assertion macros shared by the checker of the trapped water volume unit.
`ifndef TRAPPED_WATER_VOLUME_UNIT_MACROS_SVH
`define TRAPPED_WATER_VOLUME_UNIT_MACROS_SVH

// Same-cycle implication, switched off while reset is high.
`define TWV_ASSERT_NOW(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("twv check failed (same cycle)");

// Next-cycle implication, switched off while reset is high.
`define TWV_ASSERT_NEXT(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("twv check failed (next cycle)");

`endif

/* src/twv_pkg.sv */
// Shared types and constants of the trapped water volume unit.
`default_nettype none

package twv_pkg;

  localparam int unsigned VOLUME_BITS = 26;
  localparam logic [VOLUME_BITS-1:0] VOLUME_MAX = '1;

  localparam int unsigned HEIGHT_IN_BITS = 16;

  localparam int unsigned QUEUE_DEPTH = 4;

  typedef struct packed {
    logic store;    // request carries a height to write
    logic last;     // request closes the sequence
    logic dropped;  // sequence lost at least one request so far
  } twv_flags_t;

  typedef enum logic [1:0] {
    B_LOAD,
    B_WALK,
    B_DRAIN,
    B_DONE
  } twv_back_state_t;

endpackage

`default_nettype wire

/* src/trapped_water_volume_unit.sv */
// Top level of the trapped water volume unit.
// Heights stream in one request per cycle while the queue has room; the request
// with last high closes a sequence. Each stored height carries the maximum of the
// heights before it. Once a sequence is closed, the back end walks the store from
// the end to the start, keeping the maximum of later heights, and sums min(left,
// right) minus height wherever that is positive, saturating at 2^26 - 1. One
// result with the volume and an overflow flag leaves per sequence. Up to MAX_ITEMS
// heights are kept; later ones are dropped and flag overflow, but a dropped
// request that carries last still closes the sequence. The back end stores each
// height as it leaves the queue; the walk reads the store through its single read
// port into a three-stage read, compare and accumulate pipeline. During the walk
// the front end keeps taking up to four more requests into the queue, and a
// finished result waits in the output register without blocking the next walk
// from loading.
`default_nettype none

module trapped_water_volume_unit #(
  parameter int unsigned MAX_ITEMS   = 1024,
  parameter int unsigned HEIGHT_BITS = 16
) (
  input  wire logic                                clk,
  input  wire logic                                rst,
  input  wire logic                                in_valid,
  output logic                                     in_ready,
  input  wire logic [twv_pkg::HEIGHT_IN_BITS-1:0]  height,
  input  wire logic                                last,
  output logic                                     out_valid,
  input  wire logic                                out_ready,
  output logic [twv_pkg::VOLUME_BITS-1:0]          volume,
  output logic                                     overflow
);
  import twv_pkg::*;

  localparam int unsigned CNT_W = $clog2(MAX_ITEMS + 1);
  localparam int unsigned Q_W   = $bits(twv_flags_t) + CNT_W + 2 * HEIGHT_BITS;

  // Front end outputs.
  logic                   f_valid;
  logic                   f_ready;
  logic [HEIGHT_BITS-1:0] f_height;
  logic [HEIGHT_BITS-1:0] f_left_max;
  logic [CNT_W-1:0]       f_count;
  twv_flags_t             f_flags;

  // Back end inputs, as popped from the queue.
  logic                   b_valid;
  logic                   b_ready;
  logic [HEIGHT_BITS-1:0] b_height;
  logic [HEIGHT_BITS-1:0] b_left_max;
  logic [CNT_W-1:0]       b_count;
  twv_flags_t             b_flags;
  logic [Q_W-1:0]         b_data;

  // Classify each request: store it, drop it, and whether it closes the sequence.
  twv_front #(
    .MAX_ITEMS  (MAX_ITEMS),
    .HEIGHT_BITS(HEIGHT_BITS)
  ) u_front (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .height    (height),
    .last      (last),
    .q_valid   (f_valid),
    .q_ready   (f_ready),
    .e_height  (f_height),
    .e_left_max(f_left_max),
    .e_count   (f_count),
    .e_flags   (f_flags)
  );

  // Decouple the two ends so the front keeps loading while the back walks.
  twv_queue #(
    .WIDTH(Q_W)
  ) u_queue (
    .clk       (clk),
    .rst       (rst),
    .push_valid(f_valid),
    .push_ready(f_ready),
    .push_data ({f_flags, f_count, f_left_max, f_height}),
    .pop_valid (b_valid),
    .pop_ready (b_ready),
    .pop_data  (b_data)
  );

  assign {b_flags, b_count, b_left_max, b_height} = b_data;

  // Store heights, walk backward on the closing request and hold the result.
  twv_back #(
    .MAX_ITEMS  (MAX_ITEMS),
    .HEIGHT_BITS(HEIGHT_BITS)
  ) u_back (
    .clk       (clk),
    .rst       (rst),
    .q_valid   (b_valid),
    .q_ready   (b_ready),
    .e_height  (b_height),
    .e_left_max(b_left_max),
    .e_count   (b_count),
    .e_flags   (b_flags),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .volume    (volume),
    .overflow  (overflow)
  );

endmodule

`default_nettype wire

/* src/twv_front.sv */
// Front end: accepts heights, tracks left maximum, count and drops.
`default_nettype none

module twv_front #(
  parameter int unsigned MAX_ITEMS   = 1024,
  parameter int unsigned HEIGHT_BITS = 16
) (
  input  wire logic                                   clk,
  input  wire logic                                   rst,
  input  wire logic                                   in_valid,
  output logic                                        in_ready,
  input  wire logic [twv_pkg::HEIGHT_IN_BITS-1:0]     height,
  input  wire logic                                   last,
  output logic                                        q_valid,
  input  wire logic                                   q_ready,
  output logic [HEIGHT_BITS-1:0]                      e_height,
  output logic [HEIGHT_BITS-1:0]                      e_left_max,
  output logic [$clog2(MAX_ITEMS+1)-1:0]              e_count,
  output twv_pkg::twv_flags_t                         e_flags
);
  import twv_pkg::*;

  localparam int unsigned CNT_W = $clog2(MAX_ITEMS + 1);

  logic [CNT_W-1:0]       count;
  logic [HEIGHT_BITS-1:0] run_max;
  logic                   dropped;
  logic [HEIGHT_BITS-1:0] h_in;
  logic                   accept;
  logic                   fits;

  assign h_in     = HEIGHT_BITS'(height);
  assign in_ready = q_ready;
  assign accept   = in_valid && in_ready;
  assign fits     = count < CNT_W'(MAX_ITEMS);

  // Requests past capacity that do not close the sequence need no queue slot.
  assign q_valid         = in_valid && (fits || last);
  assign e_height        = h_in;
  assign e_left_max      = run_max;
  assign e_count         = fits ? count + 1'b1 : count;
  assign e_flags.store   = fits;
  assign e_flags.last    = last;
  assign e_flags.dropped = dropped || !fits;

  always_ff @(posedge clk) begin
    if (rst) begin
      count   <= '0;
      run_max <= '0;
      dropped <= 1'b0;
    end else if (accept) begin
      if (last) begin
        count   <= '0;
        run_max <= '0;
        dropped <= 1'b0;
      end else begin
        if (fits) begin
          count <= count + 1'b1;
          if (h_in > run_max) begin
            run_max <= h_in;
          end
        end else begin
          dropped <= 1'b1;
        end
      end
    end
  end

endmodule

`default_nettype wire

/* src/twv_queue.sv */
// Short request queue between the front and back ends.
`default_nettype none

module twv_queue #(
  parameter int unsigned WIDTH = 8
) (
  input  wire logic             clk,
  input  wire logic             rst,
  input  wire logic             push_valid,
  output logic                  push_ready,
  input  wire logic [WIDTH-1:0] push_data,
  output logic                  pop_valid,
  input  wire logic             pop_ready,
  output logic [WIDTH-1:0]      pop_data
);
  import twv_pkg::*;

  localparam int unsigned PTR_W = $clog2(QUEUE_DEPTH);
  localparam int unsigned FILL_W = $clog2(QUEUE_DEPTH + 1);

  logic [WIDTH-1:0]  slots [QUEUE_DEPTH];
  logic [PTR_W-1:0]  wr_ptr;
  logic [PTR_W-1:0]  rd_ptr;
  logic [FILL_W-1:0] fill;
  logic              do_push;
  logic              do_pop;

  assign push_ready = fill != FILL_W'(QUEUE_DEPTH);
  assign pop_valid  = fill != '0;
  assign pop_data   = slots[rd_ptr];
  assign do_push    = push_valid && push_ready;
  assign do_pop     = pop_valid && pop_ready;

  always_ff @(posedge clk) begin
    if (do_push) begin
      slots[wr_ptr] <= push_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      fill   <= '0;
    end else begin
      if (do_push) begin
        wr_ptr <= (wr_ptr == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr + 1'b1;
      end
      if (do_pop) begin
        rd_ptr <= (rd_ptr == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr + 1'b1;
      end
      if (do_push && !do_pop) begin
        fill <= fill + 1'b1;
      end else if (do_pop && !do_push) begin
        fill <= fill - 1'b1;
      end
    end
  end

endmodule

`default_nettype wire

/* src/twv_back.sv */
// Back end: height store, backward walk, volume accumulation and result register.
`default_nettype none

module twv_back #(
  parameter int unsigned MAX_ITEMS   = 1024,
  parameter int unsigned HEIGHT_BITS = 16
) (
  input  wire logic                                clk,
  input  wire logic                                rst,
  input  wire logic                                q_valid,
  output logic                                     q_ready,
  input  wire logic [HEIGHT_BITS-1:0]              e_height,
  input  wire logic [HEIGHT_BITS-1:0]              e_left_max,
  input  wire logic [$clog2(MAX_ITEMS+1)-1:0]      e_count,
  input  wire twv_pkg::twv_flags_t                 e_flags,
  output logic                                     out_valid,
  input  wire logic                                out_ready,
  output logic [twv_pkg::VOLUME_BITS-1:0]          volume,
  output logic                                     overflow
);
  import twv_pkg::*;

  localparam int unsigned CNT_W = $clog2(MAX_ITEMS + 1);
  localparam int unsigned AW    = (MAX_ITEMS > 1) ? $clog2(MAX_ITEMS) : 1;
  localparam int unsigned SUM_W =
    ((HEIGHT_BITS > VOLUME_BITS) ? HEIGHT_BITS : VOLUME_BITS) + 1;

  logic [2*HEIGHT_BITS-1:0] mem [MAX_ITEMS];

  twv_back_state_t state;
  twv_back_state_t state_next;

  logic                     walk_load;
  logic                     rd_en;
  logic                     res_load;
  logic [CNT_W-1:0]         walk_k;
  logic                     dropped;
  logic [AW-1:0]            rd_addr;
  logic [2*HEIGHT_BITS-1:0] rd_data;
  logic                     rd_valid;
  logic [HEIGHT_BITS-1:0]   rd_h;
  logic [HEIGHT_BITS-1:0]   rd_lm;
  logic [HEIGHT_BITS-1:0]   level;
  logic [HEIGHT_BITS-1:0]   right;
  logic [HEIGHT_BITS-1:0]   diff;
  logic                     diff_valid;
  logic [VOLUME_BITS-1:0]   acc;
  logic [SUM_W-1:0]         sum;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= B_LOAD;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    q_ready    = 1'b0;
    walk_load  = 1'b0;
    rd_en      = 1'b0;
    res_load   = 1'b0;
    case (state)
      B_LOAD: begin
        q_ready = 1'b1;
        if (q_valid && e_flags.last) begin
          walk_load  = 1'b1;
          state_next = B_WALK;
        end
      end
      B_WALK: begin
        if (walk_k == '0) begin
          state_next = B_DRAIN;
        end else begin
          rd_en = 1'b1;
          if (walk_k == CNT_W'(1)) begin
            state_next = B_DRAIN;
          end
        end
      end
      B_DRAIN: begin
        if (!rd_valid && !diff_valid) begin
          state_next = B_DONE;
        end
      end
      B_DONE: begin
        if (!out_valid || out_ready) begin
          res_load   = 1'b1;
          state_next = B_LOAD;
        end
      end
      default: begin
        state_next = B_LOAD;
      end
    endcase
  end

  // Store port: write one position per stored height, read one during the walk.
  assign rd_addr = AW'(walk_k - 1'b1);

  always_ff @(posedge clk) begin
    if (q_valid && q_ready && e_flags.store) begin
      mem[AW'(e_count - 1'b1)] <= {e_left_max, e_height};
    end
    if (rd_en) begin
      rd_data <= mem[rd_addr];
    end
  end

  always_ff @(posedge clk) begin
    if (walk_load) begin
      walk_k  <= e_count;
      dropped <= e_flags.dropped;
    end else if (rd_en) begin
      walk_k <= walk_k - 1'b1;
    end
  end

  assign rd_h  = rd_data[HEIGHT_BITS-1:0];
  assign rd_lm = rd_data[2*HEIGHT_BITS-1:HEIGHT_BITS];
  assign level = (rd_lm < right) ? rd_lm : right;
  assign sum   = SUM_W'(acc) + SUM_W'(diff);

  always_ff @(posedge clk) begin
    if (rst) begin
      rd_valid   <= 1'b0;
      diff_valid <= 1'b0;
    end else begin
      rd_valid   <= rd_en;
      diff_valid <= rd_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (walk_load) begin
      right <= '0;
    end else if (rd_valid) begin
      if (rd_h > right) begin
        right <= rd_h;
      end
    end
    if (rd_valid) begin
      diff <= (level > rd_h) ? level - rd_h : '0;
    end
  end

  always_ff @(posedge clk) begin
    if (walk_load) begin
      acc <= '0;
    end else if (diff_valid) begin
      acc <= (sum > SUM_W'(VOLUME_MAX)) ? VOLUME_MAX : sum[VOLUME_BITS-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (res_load) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (res_load) begin
      volume   <= acc;
      overflow <= dropped;
    end
  end

endmodule

`default_nettype wire

/* src/twv_checker.sv */
// Port-level checker of the trapped water volume unit and its bind.
`default_nettype none

`include "trapped_water_volume_unit_macros.svh"

module twv_checker (
  input wire logic                                clk,
  input wire logic                                rst,
  input wire logic                                in_valid,
  input wire logic                                in_ready,
  input wire logic [twv_pkg::HEIGHT_IN_BITS-1:0]  height,
  input wire logic                                last,
  input wire logic                                out_valid,
  input wire logic                                out_ready,
  input wire logic [twv_pkg::VOLUME_BITS-1:0]     volume,
  input wire logic                                overflow
);
  import twv_pkg::*;

  // Closed sequences can sit in the queue, the back end and the output register.
  localparam int unsigned PEND_MAX = QUEUE_DEPTH + 2;
  localparam int unsigned PEND_W   = $clog2(PEND_MAX + 2);

  logic [PEND_W-1:0] pending;
  logic              seq_in;
  logic              seq_out;
  logic              height_seen;

  assign seq_in      = in_valid && in_ready && last;
  assign seq_out     = out_valid && out_ready;
  assign height_seen = ^height || !(^height);

  always_ff @(posedge clk) begin
    if (rst) begin
      pending <= '0;
    end else if (seq_in && !seq_out) begin
      pending <= pending + 1'b1;
    end else if (seq_out && !seq_in) begin
      pending <= pending - 1'b1;
    end
  end

  `TWV_ASSERT_NEXT(a_out_hold, clk, rst, out_valid && !out_ready,
    out_valid && $stable(volume) && $stable(overflow))
  `TWV_ASSERT_NOW(a_no_stray_result, clk, rst, out_valid, pending != '0)
  `TWV_ASSERT_NOW(a_pending_bound, clk, rst, height_seen, pending <= PEND_W'(PEND_MAX))
  `TWV_ASSERT_NOW(a_quiet_after_reset, clk, rst, $fell(rst), !out_valid)

endmodule

bind trapped_water_volume_unit twv_checker u_twv_checker (.*);

`default_nettype wire
